@@ sv/dst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dst_pkg: shared types and constants for the set table
// Request and response words, operation codes, status codes and the
// controller state type.
// ----------------------------------------------------------------------------
package dst_pkg;

   localparam int DEF_SET_DEPTH   = 16;
   localparam int DEF_VALUE_WIDTH = 32;
   localparam int ITEM_W          = 32;
   localparam int COUNT_W         = 5;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_DUPLICATE = 2'd1,
      STAT_ABSENT    = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_CLEAR  = 2'd3
   } cell_op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      mode_type           mode;
      logic [ITEM_W-1:0]  item_value;
   } req_type;

   typedef struct packed {
      logic               was_present;
      status_type         status;
      logic [COUNT_W-1:0] member_count;
   } rsp_type;

endpackage

@@ sv/dst_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dst_cell: one entry of the set table
// Holds a value and its valid bit, compares against the broadcast key and
// passes the free-entry token on to the next cell.
// ----------------------------------------------------------------------------
module dst_cell #(
   parameter int KEY_W = dst_pkg::ITEM_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dst_pkg::cell_op_type op,
   input  logic [KEY_W-1:0]     key,
   input  logic                 free_seen_in,
   output logic                 free_seen_out,
   output logic                 match
);

   logic [KEY_W-1:0] value_ff;
   logic [KEY_W-1:0] value_in;
   logic             valid_ff;
   logic             valid_in;
   logic             claim;

   assign match         = valid_ff && (value_ff == key);
   // The lowest empty cell takes an inserted word; cells above it see the token.
   assign claim         = !valid_ff && !free_seen_in;
   assign free_seen_out = free_seen_in || !valid_ff;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (op)
         dst_pkg::CELL_INSERT: begin
            if (claim) begin
               value_in = key;
               valid_in = 1'b1;
            end
         end
         dst_pkg::CELL_REMOVE: begin
            if (match) begin
               valid_in = 1'b0;
            end
         end
         dst_pkg::CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

@@ sv/dedup_set_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_set_table: bounded set of distinct values
// Insert, remove, lookup and clear over a row of entry cells that compare
// the key in parallel and pass the lowest free entry along the row.
//
//   channel   ports                       handshake
//   request   start, busy, req_item       taken when start and not busy
//   response  rsp_valid, rsp_item         one-cycle strobe, no back-pressure
//
// A word is taken, worked while busy is high, and its response appears in the
// cycle after that; no new word is taken while busy is high.
// Synchronous reset empties the set and clears the count at once.
// The response cannot be stalled; a new word may be taken while it shows.
// ----------------------------------------------------------------------------
module dedup_set_table #(
   parameter int SET_DEPTH   = dst_pkg::DEF_SET_DEPTH,
   parameter int VALUE_WIDTH = dst_pkg::DEF_VALUE_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dst_pkg::req_type req_item,
   output logic             rsp_valid,
   output dst_pkg::rsp_type rsp_item
);

   localparam int KEY_W = (VALUE_WIDTH < dst_pkg::ITEM_W) ? VALUE_WIDTH : dst_pkg::ITEM_W;
   localparam int CNT_W = $clog2(SET_DEPTH + 1);

   dst_pkg::state_type   state_ff;
   dst_pkg::state_type   state_in;
   dst_pkg::req_type     req_ff;
   dst_pkg::req_type     req_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   dst_pkg::rsp_type     rsp_ff;
   dst_pkg::rsp_type     rsp_in;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 accept;
   logic                 exec;
   dst_pkg::cell_op_type cell_op;
   logic [KEY_W-1:0]     key;
   logic [SET_DEPTH-1:0] match;
   logic [SET_DEPTH:0]   free_chain;
   logic                 hit;
   logic                 full;
   logic [CNT_W+4:0]     count_wide;

   assign key           = req_ff.item_value[KEY_W-1:0];
   assign free_chain[0] = 1'b0;
   assign hit           = |match;
   assign full          = !free_chain[SET_DEPTH];
   assign accept        = start && !busy;

   for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
      dst_cell #(
         .KEY_W (KEY_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .op            (cell_op),
         .key           (key),
         .free_seen_in  (free_chain[i]),
         .free_seen_out (free_chain[i+1]),
         .match         (match[i])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dst_pkg::ST_IDLE: begin
            if (start) begin
               state_in = dst_pkg::ST_EXEC;
            end
         end
         dst_pkg::ST_EXEC: begin
            state_in = dst_pkg::ST_IDLE;
         end
         default: begin
            state_in = dst_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      busy = 1'b0;
      exec = 1'b0;
      unique case (state_ff)
         dst_pkg::ST_IDLE: begin
         end
         dst_pkg::ST_EXEC: begin
            busy = 1'b1;
            exec = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Operation decode and response word.
   always_comb begin
      cell_op  = dst_pkg::CELL_HOLD;
      count_in = count_ff;
      rsp_in   = rsp_ff;
      req_in   = accept ? req_item : req_ff;
      rsp_in.was_present = hit;
      rsp_in.status      = dst_pkg::STAT_DONE;
      unique case (req_ff.mode)
         dst_pkg::MODE_INSERT: begin
            if (hit) begin
               rsp_in.status = dst_pkg::STAT_DUPLICATE;
            end else if (full) begin
               rsp_in.status = dst_pkg::STAT_FULL;
            end else begin
               cell_op  = dst_pkg::CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         dst_pkg::MODE_REMOVE: begin
            if (hit) begin
               cell_op  = dst_pkg::CELL_REMOVE;
               count_in = count_ff - 1'b1;
            end else begin
               rsp_in.status = dst_pkg::STAT_ABSENT;
            end
         end
         dst_pkg::MODE_LOOKUP: begin
            if (!hit) begin
               rsp_in.status = dst_pkg::STAT_ABSENT;
            end
         end
         dst_pkg::MODE_CLEAR: begin
            cell_op            = dst_pkg::CELL_CLEAR;
            count_in           = '0;
            rsp_in.was_present = 1'b0;
         end
         default: begin
         end
      endcase
      if (!exec) begin
         cell_op  = dst_pkg::CELL_HOLD;
         count_in = count_ff;
      end
      count_wide          = {5'd0, count_in};
      rsp_in.member_count = count_wide[dst_pkg::COUNT_W-1:0];
      rsp_valid_in        = exec;
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= dst_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_exec_then_rsp : assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid)
      else $error("response did not follow the working cycle");

   a_rsp_after_exec : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(exec))
      else $error("response without a working cycle");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SET_DEPTH))
      else $error("member count above the table depth");

   a_full_absent : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status == dst_pkg::STAT_FULL) |-> !rsp_item.was_present)
      else $error("full status reported for a present word");

endmodule
